### hw/rtl/aetr_pkg.sv
// ----------------------------------------------------------------------------
// Alarm entry time resolver package
// Shared types, register indexes, calendar constants and helper functions.
// ----------------------------------------------------------------------------
package aetr_pkg;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 31;

    localparam logic [CFG_IDX_W-1:0] CFG_NOW_SECONDS    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NOW_MONTH      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NOW_DAY        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_NOW_YEAR       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_NOW_WEEKDAY    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ZONE_OFFSET    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_HISTORY_WINDOW = 3'd6;

    // entry kinds
    localparam logic [1:0] REQ_BLANK  = 2'd0;
    localparam logic [1:0] REQ_DATE   = 2'd1;
    localparam logic [1:0] REQ_DAILY  = 2'd2;
    localparam logic [1:0] REQ_WEEKLY = 2'd3;

    // day count (signed, -1 .. ~62500) and second count widths
    localparam int DAYS_W = 18;
    localparam int WHEN_W = 36;

    localparam logic [7:0] BASE_YEAR = 8'd86;

    localparam logic signed [WHEN_W-1:0] SECS_DAY_W  = 36'sd86400;
    localparam logic signed [WHEN_W-1:0] HALF_DAY_W  = 36'sd43200;
    localparam logic signed [WHEN_W-1:0] EPOCH_1986  = 36'sd504921600;
    localparam logic [16:0]              SECS_HOUR   = 17'd3600;
    localparam logic [11:0]              SECS_MIN    = 12'd60;

    typedef logic signed [DAYS_W-1:0] days_t;
    typedef logic signed [WHEN_W-1:0] when_t;

    typedef struct packed {
        logic [1:0] req_type;
        logic [3:0] entry_month;
        logic [4:0] entry_day;
        logic [2:0] entry_weekday;
        logic [4:0] entry_hour;
        logic [5:0] entry_minute;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] alarm_seconds;
        logic               accepted;
    } out_item_t;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic prep;
        logic year_step;
        logic mul;
        logic sum;
        logic rel;
        logic adj;
        logic out_load;
    } ctrl_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic year_done;
    } ctrl_status_t;

    function automatic logic [3:0] clamp_month(input logic [3:0] m);
        logic [3:0] r;
        if (m == 4'd0)
            r = 4'd1;
        else if (m > 4'd12)
            r = 4'd12;
        else
            r = m;
        return r;
    endfunction

    // correction from 30-day months to the real day of year
    function automatic logic signed [3:0] month_fix(input logic [3:0] mi);
        logic signed [3:0] r;
        case (mi)
            4'd0:    r = 4'sd0;
            4'd1:    r = 4'sd1;
            4'd2:    r = -4'sd1;
            4'd3:    r = 4'sd0;
            4'd4:    r = 4'sd0;
            4'd5:    r = 4'sd1;
            4'd6:    r = 4'sd1;
            4'd7:    r = 4'sd2;
            4'd8:    r = 4'sd3;
            4'd9:    r = 4'sd3;
            4'd10:   r = 4'sd4;
            4'd11:   r = 4'sd4;
            default: r = 4'sd0;
        endcase
        return r;
    endfunction

    // years since 1900; 1900 and 2100 are not leap, 2000 is
    function automatic logic is_leap(input logic [7:0] y);
        return (y[1:0] == 2'b00) && (y != 8'd0) && (y != 8'd200);
    endfunction

    // v in 0..14
    function automatic logic [2:0] mod7(input logic [3:0] v);
        logic [3:0] r;
        if (v >= 4'd14)
            r = v - 4'd14;
        else if (v >= 4'd7)
            r = v - 4'd7;
        else
            r = v;
        return r[2:0];
    endfunction

endpackage

### hw/rtl/aetr_in_if.sv
// ----------------------------------------------------------------------------
// Alarm entry input channel
// Valid/ready channel carrying one parsed alarm entry per beat.
// ----------------------------------------------------------------------------
interface aetr_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] req_type;
    logic [3:0] entry_month;
    logic [4:0] entry_day;
    logic [2:0] entry_weekday;
    logic [4:0] entry_hour;
    logic [5:0] entry_minute;

    modport source (
        output valid, req_type, entry_month, entry_day, entry_weekday,
               entry_hour, entry_minute,
        input  ready
    );

    modport sink (
        input  valid, req_type, entry_month, entry_day, entry_weekday,
               entry_hour, entry_minute,
        output ready
    );
endinterface

### hw/rtl/aetr_out_if.sv
// ----------------------------------------------------------------------------
// Alarm time output channel
// Valid/ready channel carrying one resolved alarm time per beat.
// ----------------------------------------------------------------------------
interface aetr_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] alarm_seconds;
    logic               accepted;

    modport source (
        output valid, alarm_seconds, accepted,
        input  ready
    );

    modport sink (
        input  valid, alarm_seconds, accepted,
        output ready
    );
endinterface

### hw/rtl/aetr_dp.sv
// ----------------------------------------------------------------------------
// Alarm entry time resolver datapath
// Config registers, entry latch, day accumulator with year loop, seconds
// multiply, daily window fold and the output register.
// ----------------------------------------------------------------------------
module aetr_dp #(
    parameter int MAX_YEAR = 137
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [aetr_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [aetr_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  aetr_pkg::in_item_t                 in_item,
    input  aetr_pkg::ctrl_cmd_t                cmd,
    output aetr_pkg::ctrl_status_t             status,
    output aetr_pkg::out_item_t                out_item
);
    import aetr_pkg::*;

    localparam logic [7:0] MAX_Y = 8'(MAX_YEAR);

    // configuration
    logic [30:0]        now_seconds_reg;
    logic [3:0]         now_month_reg;
    logic [4:0]         now_day_reg;
    logic [7:0]         now_year_reg;
    logic [2:0]         now_weekday_reg;
    logic signed [16:0] zone_offset_reg;
    logic signed [12:0] history_window_reg;

    // working registers
    in_item_t           entry_reg;
    logic               daily_reg;
    logic               blank_reg;
    logic [7:0]         year_reg;
    logic [7:0]         cursor_reg;
    days_t              days_reg;
    when_t              tod_reg;
    when_t              dsec_reg;
    when_t              when_reg;
    when_t              rel_reg;
    out_item_t          out_reg;

    // prep stage
    logic [3:0]  cm;
    logic [3:0]  month;
    logic [5:0]  day;
    logic [2:0]  wofs;
    logic        passed;
    logic [8:0]  yr9;
    logic [7:0]  year;
    logic [3:0]  mi;
    logic [9:0]  b30;
    logic signed [3:0] fix;
    days_t       base_days;
    logic [16:0] hour_sec;
    logic [11:0] min_sec;
    when_t       tod;
    when_t       dsec;
    when_t       now_s;
    when_t       hist_s;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            now_seconds_reg    <= '0;
            now_month_reg      <= 4'd1;
            now_day_reg        <= 5'd1;
            now_year_reg       <= BASE_YEAR;
            now_weekday_reg    <= '0;
            zone_offset_reg    <= '0;
            history_window_reg <= -13'sd3600;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_NOW_SECONDS:    now_seconds_reg    <= cfg_wdata;
                CFG_NOW_MONTH:      now_month_reg      <= cfg_wdata[3:0];
                CFG_NOW_DAY:        now_day_reg        <= cfg_wdata[4:0];
                CFG_NOW_YEAR:       now_year_reg       <= cfg_wdata[7:0];
                CFG_NOW_WEEKDAY:    now_weekday_reg    <= cfg_wdata[2:0];
                CFG_ZONE_OFFSET:    zone_offset_reg    <= cfg_wdata[16:0];
                CFG_HISTORY_WINDOW: history_window_reg <= cfg_wdata[12:0];
                default:            ;
            endcase
        end
    end

    always_comb
    begin
        cm   = clamp_month(now_month_reg);
        wofs = mod7(4'({1'b0, entry_reg.entry_weekday}) + 4'd7
                    - 4'({1'b0, now_weekday_reg}));
        case (entry_reg.req_type)
            REQ_DATE:
            begin
                month = clamp_month(entry_reg.entry_month);
                day   = {1'b0, entry_reg.entry_day};
            end
            REQ_WEEKLY:
            begin
                month = cm;
                day   = {1'b0, now_day_reg} + {3'b000, wofs};
            end
            default:
            begin
                month = cm;
                day   = {1'b0, now_day_reg};
            end
        endcase

        passed = !((month > cm) || ((month == cm) && (day >= {1'b0, now_day_reg})));
        yr9    = {1'b0, now_year_reg} + {8'd0, passed};
        year   = (yr9 > {1'b0, MAX_Y}) ? MAX_Y : yr9[7:0];

        mi  = month - 4'd1;
        b30 = {6'd0, mi} * 10'd30;
        fix = month_fix(mi);
        base_days = $signed({8'd0, b30}) + $signed({12'd0, day}) - 18'sd1
                    + {{(DAYS_W-4){fix[3]}}, fix}
                    + $signed({17'd0, (mi > 4'd1) && is_leap(year)});

        hour_sec = {12'd0, entry_reg.entry_hour} * SECS_HOUR;
        min_sec  = {6'd0, entry_reg.entry_minute} * SECS_MIN;
        tod = EPOCH_1986 + {{(WHEN_W-17){zone_offset_reg[16]}}, zone_offset_reg}
              + $signed({19'd0, hour_sec}) + $signed({24'd0, min_sec});
    end

    assign dsec   = $signed({{(WHEN_W-DAYS_W){days_reg[DAYS_W-1]}}, days_reg}) * SECS_DAY_W;
    assign now_s  = $signed({5'd0, now_seconds_reg});
    assign hist_s = {{(WHEN_W-13){history_window_reg[12]}}, history_window_reg};

    assign status.year_done = (cursor_reg >= year_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
            entry_reg <= in_item;

        if (cmd.prep)
        begin
            daily_reg  <= (entry_reg.req_type == REQ_DAILY);
            blank_reg  <= (entry_reg.req_type == REQ_BLANK);
            year_reg   <= year;
            cursor_reg <= BASE_YEAR;
            days_reg   <= base_days;
            tod_reg    <= tod;
        end

        // whole years from 1986 up to the target year, one per cycle
        if (cmd.year_step)
        begin
            days_reg   <= days_reg + (is_leap(cursor_reg) ? 18'sd366 : 18'sd365);
            cursor_reg <= cursor_reg + 8'd1;
        end

        if (cmd.mul)
            dsec_reg <= dsec;

        if (cmd.sum)
            when_reg <= blank_reg ? '0 : dsec_reg + tod_reg;

        if (cmd.rel)
            rel_reg <= when_reg - now_s;

        // daily alarms fold into +-12 h around now
        if (cmd.adj && daily_reg)
        begin
            if (rel_reg > HALF_DAY_W)
            begin
                rel_reg  <= rel_reg - SECS_DAY_W;
                when_reg <= when_reg - SECS_DAY_W;
            end
            else if (rel_reg < -HALF_DAY_W)
            begin
                rel_reg  <= rel_reg + SECS_DAY_W;
                when_reg <= when_reg + SECS_DAY_W;
            end
        end

        if (cmd.out_load)
        begin
            out_reg.alarm_seconds <= when_reg[31:0];
            out_reg.accepted      <= (rel_reg < HALF_DAY_W) && (rel_reg >= hist_s);
        end
    end

    assign out_item = out_reg;

endmodule

### hw/rtl/aetr_ctrl.sv
// ----------------------------------------------------------------------------
// Alarm entry time resolver controller
// Sequences one entry through prep, year loop, multiply, sum and window fold,
// and manages the output register handshake.
// ----------------------------------------------------------------------------
module aetr_ctrl (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    output logic                    out_valid,
    input  logic                    out_ready,
    input  aetr_pkg::ctrl_status_t  status,
    output aetr_pkg::ctrl_cmd_t     cmd
);
    import aetr_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_PREP = 3'd1;
    localparam logic [2:0] S_YEAR = 3'd2;
    localparam logic [2:0] S_MUL  = 3'd3;
    localparam logic [2:0] S_SUM  = 3'd4;
    localparam logic [2:0] S_REL  = 3'd5;
    localparam logic [2:0] S_ADJ  = 3'd6;
    localparam logic [2:0] S_DONE = 3'd7;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       out_free;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_free  = !out_valid_reg || out_ready;

    always_comb
    begin
        cmd            = '0;
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_PREP;
                end
            end
            S_PREP:
            begin
                cmd.prep   = 1'b1;
                state_next = S_YEAR;
            end
            S_YEAR:
            begin
                if (status.year_done)
                    state_next = S_MUL;
                else
                    cmd.year_step = 1'b1;
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_SUM;
            end
            S_SUM:
            begin
                cmd.sum    = 1'b1;
                state_next = S_REL;
            end
            S_REL:
            begin
                cmd.rel    = 1'b1;
                state_next = S_ADJ;
            end
            S_ADJ:
            begin
                cmd.adj    = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result register never overwritten while a beat is still pending
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || out_ready))
        else $error("output register loaded while holding an untaken beat");

    a_accept_to_prep: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == S_PREP))
        else $error("accepted entry did not start prep");

    a_cmd_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load, cmd.prep, cmd.year_step, cmd.mul, cmd.sum,
                  cmd.rel, cmd.adj, cmd.out_load}))
        else $error("more than one datapath command at once");

    a_year_exit: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_YEAR) && status.year_done) |=> (state_reg == S_MUL))
        else $error("year loop did not exit when done");

    a_load_gives_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> out_valid_reg)
        else $error("loaded result not presented");

endmodule

### hw/rtl/alarm_entry_time_resolver_unit.sv
// ----------------------------------------------------------------------------
// Alarm entry time resolver
// Turns one parsed alarm entry (specific date, daily, weekly or blank) into
// epoch seconds plus an in-window flag. The result beat is presented after
// the prep state, a year loop in which the day accumulator adds one whole
// year length per cycle for each year from 86 up to the target year Y (years
// since 1900, saturated at MAX_YEAR), and the multiply, sum, rel and adjust
// states; the sequencer is idle again as the result is loaded. The input is
// ready whenever the sequencer is idle; a finished result sits in an output
// register, so the next entry is taken while the previous beat waits, and
// that entry stalls at its end only while the earlier beat is still untaken.
// The user must set the current date, zone offset and history window through
// the write port while no entry is in flight; the block does not enforce it.
// ----------------------------------------------------------------------------
module alarm_entry_time_resolver_unit #(
    parameter int MAX_YEAR = 137
) (
    input  logic                             clk,
    input  logic                             rst_n,
    aetr_in_if.sink                          in_ch,
    aetr_out_if.source                       out_ch,
    input  logic                             cfg_we,
    input  logic [aetr_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [aetr_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
    import aetr_pkg::*;

    ctrl_cmd_t    cmd;
    ctrl_status_t status;
    in_item_t     in_item;
    out_item_t    out_item;

    assign in_item.req_type      = in_ch.req_type;
    assign in_item.entry_month   = in_ch.entry_month;
    assign in_item.entry_day     = in_ch.entry_day;
    assign in_item.entry_weekday = in_ch.entry_weekday;
    assign in_item.entry_hour    = in_ch.entry_hour;
    assign in_item.entry_minute  = in_ch.entry_minute;

    assign out_ch.alarm_seconds = out_item.alarm_seconds;
    assign out_ch.accepted      = out_item.accepted;

    aetr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .status    (status),
        .cmd       (cmd)
    );

    aetr_dp #(
        .MAX_YEAR (MAX_YEAR)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .in_item   (in_item),
        .cmd       (cmd),
        .status    (status),
        .out_item  (out_item)
    );

endmodule
